// ===== sv/lpgd_pkg.sv =====
// shared types and constants for the length-prefixed goto deframer
// no dependencies; used by every module of the block
package lpgd_pkg;

    typedef enum logic [1:0] {
        EV_GOTO       = 2'd0,
        EV_SKIP       = 2'd1,
        EV_BAD_LEN    = 2'd2,
        EV_SHORT_GOTO = 2'd3
    } t_event;

    localparam logic [15:0] FRAME_MIN_LEN = 16'd4;
    localparam logic [15:0] GOTO_MIN_LEN  = 16'd20;
    localparam logic [15:0] MAX_LEN_RESET = 16'd120;
    localparam logic [15:0] GOTO_TYPE     = 16'd0;

    localparam int CT_BASE  = 4;
    localparam int RA_BASE  = 12;
    localparam int DEC_BASE = 16;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic signed [63:0] current_time;
    } t_in_item;

    typedef struct packed {
        t_event             event_res;
        logic [15:0]        packet_type;
        logic [31:0]        right_ascension;
        logic signed [31:0] declination;
        logic signed [63:0] time_offset;
    } t_out_item;

endpackage

// ===== sv/lpgd_core.sv =====
// per-byte deframing: frame state registers and result formation
// depends on lpgd_pkg
module lpgd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lpgd_pkg::t_in_item i_item,
    input  logic [15:0]       i_max_len,
    output logic              o_res_valid,
    output lpgd_pkg::t_out_item o_res
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_frame_type, n_frame_type;
    logic [63:0] r_client, n_client;
    logic [31:0] r_ra, n_ra;
    logic [31:0] r_dec, n_dec;
    logic        r_closed, n_closed;

    logic [15:0] idx;
    logic [7:0]  b;
    logic        bad_len;
    logic        frame_end;

    always_comb begin
        n_byte_index = r_byte_index;
        n_frame_len  = r_frame_len;
        n_frame_type = r_frame_type;
        n_client     = r_client;
        n_ra         = r_ra;
        n_dec        = r_dec;
        n_closed     = r_closed;
        o_res_valid  = 1'b0;
        o_res        = '0;
        idx          = r_byte_index;
        b            = i_item.data_byte;
        bad_len      = 1'b0;
        frame_end    = ({1'b0, idx} + 17'd1) == {1'b0, r_frame_len};

        if (i_fire && !r_closed) begin
            n_byte_index = idx + 16'd1;
            if (idx == 16'd0) begin
                n_frame_len  = {8'h00, b};
                n_frame_type = '0;
                n_client     = '0;
                n_ra         = '0;
                n_dec        = '0;
            end else if (idx == 16'd1) begin
                n_frame_len = {b, r_frame_len[7:0]};
                if (n_frame_len < lpgd_pkg::FRAME_MIN_LEN || n_frame_len > i_max_len) begin
                    bad_len            = 1'b1;
                    n_closed           = 1'b1;
                    n_byte_index       = '0;
                    o_res_valid        = 1'b1;
                    o_res.event_res    = lpgd_pkg::EV_BAD_LEN;
                end
            end else if (idx == 16'd2) begin
                n_frame_type = {8'h00, b};
            end else if (idx == 16'd3) begin
                n_frame_type = {b, r_frame_type[7:0]};
            end else begin
                for (int k = 0; k < 8; k++) begin
                    if (idx == 16'(lpgd_pkg::CT_BASE + k)) n_client[8*k +: 8] = b;
                end
                for (int k = 0; k < 4; k++) begin
                    if (idx == 16'(lpgd_pkg::RA_BASE + k)) n_ra[8*k +: 8] = b;
                    if (idx == 16'(lpgd_pkg::DEC_BASE + k)) n_dec[8*k +: 8] = b;
                end
            end

            if (!bad_len && idx >= 16'd3 && frame_end) begin
                n_byte_index = '0;
                o_res_valid  = 1'b1;
                if (n_frame_type != lpgd_pkg::GOTO_TYPE) begin
                    o_res.event_res   = lpgd_pkg::EV_SKIP;
                    o_res.packet_type = n_frame_type;
                end else if (r_frame_len < lpgd_pkg::GOTO_MIN_LEN) begin
                    n_closed        = 1'b1;
                    o_res.event_res = lpgd_pkg::EV_SHORT_GOTO;
                end else begin
                    o_res.event_res       = lpgd_pkg::EV_GOTO;
                    o_res.right_ascension = n_ra;
                    o_res.declination     = n_dec;
                    o_res.time_offset     = i_item.current_time - r_client;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_frame_len  <= '0;
            r_frame_type <= '0;
            r_client     <= '0;
            r_ra         <= '0;
            r_dec        <= '0;
            r_closed     <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_frame_len  <= n_frame_len;
            r_frame_type <= n_frame_type;
            r_client     <= n_client;
            r_ra         <= n_ra;
            r_dec        <= n_dec;
            r_closed     <= n_closed;
        end
    end

endmodule

// ===== sv/lpgd_out_queue.sv =====
// two-entry result queue: a two-slot ring with read and write pointers
// depends on lpgd_pkg
module lpgd_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lpgd_pkg::t_out_item i_res,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output lpgd_pkg::t_out_item o_data
);

    lpgd_pkg::t_out_item r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = r_count != 2'd0;
    assign o_full  = r_count == 2'd2;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop) r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/length_prefixed_goto_deframer.sv =====
// path of a byte: input register r_in, then lpgd_core, then a result queue entry shown on o_valid
// throughput: one byte per cycle while o_stall is low; a byte that ends no packet gives no result
// a two-entry result queue; input stalls only while a byte waits and both entries hold results
// reset clears frame state, reopens the link and sets max length to 120
// depends on lpgd_pkg, lpgd_core, lpgd_out_queue
module length_prefixed_goto_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  lpgd_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output lpgd_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic               r_in_vld;
    lpgd_pkg::t_in_item r_in;
    logic [15:0]        r_max_len;
    logic               q_full;
    logic               fire;
    logic               accept;
    logic               res_valid;
    lpgd_pkg::t_out_item res;

    assign o_cfg_ready = 1'b1;
    assign fire        = r_in_vld && !q_full;
    assign o_stall     = r_in_vld && q_full;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_max_len <= lpgd_pkg::MAX_LEN_RESET;
        end else begin
            if (accept) r_in_vld <= 1'b1;
            else if (fire) r_in_vld <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_in <= i_data;
    end

    lpgd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpgd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== sv/lpgd_checker.sv =====
// port-level checks for the deframer, attached by bind
// depends on lpgd_pkg and length_prefixed_goto_deframer
module lpgd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input lpgd_pkg::t_out_item o_data,
    input logic                o_cfg_ready
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // only goto carries position and time
    a_non_goto_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.event_res != lpgd_pkg::EV_GOTO |->
            o_data.right_ascension == '0 && o_data.declination == '0 &&
            o_data.time_offset == '0)
        else $error("non-goto result carries payload");

    a_type_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.event_res == lpgd_pkg::EV_BAD_LEN ||
                    o_data.event_res == lpgd_pkg::EV_SHORT_GOTO ||
                    o_data.event_res == lpgd_pkg::EV_GOTO) |->
            o_data.packet_type == '0)
        else $error("packet type set on goto or error result");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind length_prefixed_goto_deframer lpgd_checker u_lpgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data      (o_data),
    .o_cfg_ready (o_cfg_ready)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for length_prefixed_goto_deframer: drives the byte stream, stalls
// results at random, checks each against an in-bench predictor or DIR_TAB; needs lpgd_pkg
module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        CLOSE_RUNT,
        CLOSE_OVERSIZE,
        CLOSE_SHORT_GOTO,
        CLOSE_TINY_MAX
    } t_close_mode;

    typedef struct packed {
        logic [7:0]          b;
        logic [63:0]         t;
        logic                typed;
        lpgd_pkg::t_out_item res;
    } t_dir_row;

    localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam lpgd_pkg::t_out_item NO_RES = '0;
    localparam lpgd_pkg::t_out_item SKIP_RES =
        '{lpgd_pkg::EV_SKIP, 16'hFFFF, 32'h0, 32'sh0, 64'sh0};
    localparam lpgd_pkg::t_out_item GOTO_RES =
        '{lpgd_pkg::EV_GOTO, 16'h0, 32'hFFFF_FFFF, 32'sh8000_0000, 64'shFFFF_FFFF_FFFF_FFFF};

    // shortest unknown-type packet, then a goto with extreme fields
    localparam t_dir_row DIR_TAB [0:23] = '{
        '{8'h04, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b1, SKIP_RES},
        '{8'h14, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h80, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b0, NO_RES},
        '{8'hFF, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h00, 64'h0, 1'b0, NO_RES},
        '{8'h80, T_MAX, 1'b1, GOTO_RES}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    lpgd_pkg::t_in_item  in_data = '0;
    logic                dut_stall;
    logic                out_valid;
    logic                out_stall = 1'b0;
    lpgd_pkg::t_out_item out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = '0;

    // predictor state
    logic [15:0] max_len = lpgd_pkg::MAX_LEN_RESET;
    logic [15:0] rx_idx = '0;
    logic [15:0] rx_len = '0;
    logic [15:0] rx_type = '0;
    logic [63:0] rx_ct = '0;
    logic [31:0] rx_ra = '0;
    logic [31:0] rx_dec = '0;
    logic        rx_closed = 1'b0;

    lpgd_pkg::t_out_item pending_results [$];
    lpgd_pkg::t_out_item want;
    int        mismatch_cnt = 0;
    int        bytes_sent = 0;
    int        stall_left = 0;
    int        cycle_cnt = 0;
    bit        no_idle = 1'b0;

    length_prefixed_goto_deframer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (dut_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit deframe_byte(input lpgd_pkg::t_in_item item,
                                        output lpgd_pkg::t_out_item res);
        logic [7:0] b;
        b = item.data_byte;
        res = '0;
        if (rx_closed) begin
            return 1'b0;
        end
        case (rx_idx)
            16'd0: begin
                rx_len = {8'h00, b};
                rx_type = '0;
                rx_ct = '0;
                rx_ra = '0;
                rx_dec = '0;
            end
            16'd1: begin
                rx_len[15:8] = b;
                if (rx_len < lpgd_pkg::FRAME_MIN_LEN || rx_len > max_len) begin
                    rx_closed = 1'b1;
                    rx_idx = '0;
                    res.event_res = lpgd_pkg::EV_BAD_LEN;
                    return 1'b1;
                end
            end
            16'd2: rx_type = {8'h00, b};
            16'd3: rx_type[15:8] = b;
            default: begin
                if (rx_idx < lpgd_pkg::RA_BASE) begin
                    rx_ct[8 * (rx_idx - lpgd_pkg::CT_BASE) +: 8] = b;
                end else if (rx_idx < lpgd_pkg::DEC_BASE) begin
                    rx_ra[8 * (rx_idx - lpgd_pkg::RA_BASE) +: 8] = b;
                end else if (rx_idx < lpgd_pkg::GOTO_MIN_LEN) begin
                    rx_dec[8 * (rx_idx - lpgd_pkg::DEC_BASE) +: 8] = b;
                end
            end
        endcase
        if (rx_idx >= 16'd3 && {1'b0, rx_idx} + 17'd1 == {1'b0, rx_len}) begin
            rx_idx = '0;
            if (rx_type != lpgd_pkg::GOTO_TYPE) begin
                res.event_res = lpgd_pkg::EV_SKIP;
                res.packet_type = rx_type;
            end else if (rx_len < lpgd_pkg::GOTO_MIN_LEN) begin
                rx_closed = 1'b1;
                res.event_res = lpgd_pkg::EV_SHORT_GOTO;
            end else begin
                res.event_res = lpgd_pkg::EV_GOTO;
                res.right_ascension = rx_ra;
                res.declination = rx_dec;
                res.time_offset = item.current_time - rx_ct;
            end
            return 1'b1;
        end
        rx_idx = rx_idx + 16'd1;
        return 1'b0;
    endfunction

    function automatic logic [63:0] rand_time();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return T_MAX;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic [63:0] t, input logic typed,
                             input lpgd_pkg::t_out_item typed_res);
        int                  gap;
        lpgd_pkg::t_in_item  item;
        lpgd_pkg::t_out_item res;
        bit                  got;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        item.data_byte = b;
        item.current_time = t;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        got = deframe_byte(item, res);
        if (typed) begin
            pending_results.push_back(typed_res);
        end else if (got) begin
            pending_results.push_back(res);
        end
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [15:0] len, input logic [15:0] typ);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            case (k)
                0: b = len[7:0];
                1: b = len[15:8];
                2: b = typ[7:0];
                3: b = typ[15:8];
                default: b = 8'($urandom);
            endcase
            push_byte(b, rand_time(), 1'b0, NO_RES);
        end
    endtask

    task automatic random_packets(input int budget);
        int          stop;
        int          cap;
        logic [15:0] len;
        logic [15:0] typ;
        stop = bytes_sent + budget;
        while (bytes_sent < stop) begin
            cap = ($urandom_range(0, 9) == 0) ? 300 : 40;
            if (cap > max_len) begin
                cap = max_len;
            end
            if (max_len >= lpgd_pkg::GOTO_MIN_LEN && $urandom_range(0, 9) < 7) begin
                typ = lpgd_pkg::GOTO_TYPE;
                len = 16'($urandom_range(lpgd_pkg::GOTO_MIN_LEN, cap));
            end else begin
                typ = 16'($urandom_range(1, 16'hFFFF));
                len = 16'($urandom_range(lpgd_pkg::FRAME_MIN_LEN, cap));
            end
            send_packet(len, typ);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        max_len = v;
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, out_data);
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", want.event_res, out_data.event_res);
                    check_field("packet_type", want.packet_type, out_data.packet_type);
                    check_field("right_ascension", want.right_ascension,
                                out_data.right_ascension);
                    check_field("declination", want.declination, out_data.declination);
                    check_field("time_offset", want.time_offset, out_data.time_offset);
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("length_prefixed_goto_deframer: mismatch");
            $finish;
        end
    end

    initial begin
        t_close_mode mode;
        logic [15:0] len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int r = 0; r < 24; r++) begin
            push_byte(DIR_TAB[r].b, DIR_TAB[r].t, DIR_TAB[r].typed, DIR_TAB[r].res);
        end

        write_max(16'hFFFF);
        random_packets(150);
        send_packet(16'd200, lpgd_pkg::GOTO_TYPE);
        no_idle = 1'b1;
        send_packet(16'd64, 16'($urandom_range(1, 16'hFFFF)));
        no_idle = 1'b0;

        write_max(lpgd_pkg::FRAME_MIN_LEN);
        random_packets(80);

        write_max(16'($urandom_range(21, 300)));
        random_packets(150);
        no_idle = 1'b1;
        random_packets(100);
        no_idle = 1'b0;

        write_max(lpgd_pkg::GOTO_MIN_LEN);
        random_packets(120);

        // the link closes for good, so exactly one closing case per run
        mode = t_close_mode'($urandom_range(0, 3));
        case (mode)
            CLOSE_RUNT: begin
                len = 16'($urandom_range(0, 3));
                push_byte(len[7:0], rand_time(), 1'b0, NO_RES);
                push_byte(len[15:8], rand_time(), 1'b0, NO_RES);
            end
            CLOSE_OVERSIZE: begin
                len = 16'($urandom_range(max_len + 1, 16'hFFFF));
                push_byte(len[7:0], rand_time(), 1'b0, NO_RES);
                push_byte(len[15:8], rand_time(), 1'b0, NO_RES);
            end
            CLOSE_SHORT_GOTO: begin
                send_packet(16'($urandom_range(lpgd_pkg::FRAME_MIN_LEN,
                                               lpgd_pkg::GOTO_MIN_LEN - 1)),
                            lpgd_pkg::GOTO_TYPE);
            end
            default: begin
                write_max(16'($urandom_range(0, 3)));
                len = 16'($urandom);
                push_byte(len[7:0], rand_time(), 1'b0, NO_RES);
                push_byte(len[15:8], rand_time(), 1'b0, NO_RES);
            end
        endcase
        repeat (30) push_byte(8'($urandom), rand_time(), 1'b0, NO_RES);

        settle();
        repeat (6) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("length_prefixed_goto_deframer: match");
        end else begin
            $display("length_prefixed_goto_deframer: mismatch");
        end
        $finish;
    end

endmodule
